@@ hdl/dis_pkg.sv @@
package dis_pkg;

  typedef logic [31:0] bound_t;

  localparam logic [2:0] OP_CONTAINS  = 3'd0;
  localparam logic [2:0] OP_UNION     = 3'd1;
  localparam logic [2:0] OP_SUBTRACT  = 3'd2;
  localparam logic [2:0] OP_INTERSECT = 3'd3;
  localparam logic [2:0] OP_SHIFT_UP  = 3'd4;
  localparam logic [2:0] OP_SHIFT_DN  = 3'd5;
  localparam logic [2:0] OP_READ      = 3'd6;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_RANGE = 2'd2;

  localparam bound_t BOUND_MAX = 32'hFFFF_FFFF;

endpackage

@@ hdl/dis_if.sv @@
interface dis_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] range_low;
  logic [31:0] range_high;
  logic [31:0] operand_value;
  logic [3:0]  entry_index;

  modport source (output valid, opcode, range_low, range_high, operand_value, entry_index,
                  input ready);
  modport sink   (input valid, opcode, range_low, range_high, operand_value, entry_index,
                  output ready);
endinterface

interface dis_rsp_if #(parameter int CNT_W = 5);
  logic             valid;
  logic             ready;
  logic             is_member;
  logic [31:0]      entry_low;
  logic [31:0]      entry_high;
  logic             entry_valid;
  logic [CNT_W-1:0] range_count;
  logic [1:0]       status;

  modport source (output valid, is_member, entry_low, entry_high, entry_valid, range_count,
                  status, input ready);
  modport sink   (input valid, is_member, entry_low, entry_high, entry_valid, range_count,
                  status, output ready);
endinterface

@@ hdl/disjoint_interval_set.sv @@
// Sorted set of disjoint closed 32-bit ranges.
// req_i takes one request per operation (contains, union, subtract, intersect,
// shift up, shift down, read entry); rsp_o returns exactly one response each.
// The table lives in a two-bank synchronous RAM. An update reads the current
// bank one entry at a time and writes the new table into the other bank; the
// banks swap only if the new table fits, so a rejected request leaves the set
// unchanged.
// Contains and the updates step through the stored ranges, reading and then
// evaluating each, and end in a finish state; union adds a step to emit its
// merged range, and subtract adds one when it splits a range.
// Shift up stops at the first overflowing range. Read entry reads only the
// indexed entry, if it is stored; a bad range or unused opcode goes straight to
// the finish state. Requests are handled one at a time; req_i.ready is high
// only in the idle state.
// The response sits in an output register; a stalled receiver holds it and the
// block stops before loading the next response, but it takes the next request.
// Reset empties the set (count 0); RAM contents need no clearing.
module disjoint_interval_set #(
  parameter int MAX_RANGES = 16,
  parameter int CNT_W      = $clog2(MAX_RANGES + 1)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dis_req_if.sink   req_i,
  dis_rsp_if.source rsp_o
);
  import dis_pkg::*;

  localparam int AW  = $clog2(MAX_RANGES);
  localparam int WCW = CNT_W + 1;
  localparam int IXW = (CNT_W > 4) ? CNT_W : 4;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_EV2  = 3'd3;
  localparam logic [2:0] S_UFIN = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [63:0] mem [2**(AW+1)];
  logic [63:0] rd_q;

  logic [2:0]       state_q;
  logic             bank_q;
  logic [CNT_W-1:0] count_q;
  logic [WCW-1:0]   wcnt_q;
  logic [AW-1:0]    i_q;
  logic [2:0]       op_q;
  bound_t           lo_q, hi_q, val_q;
  bound_t           mlo_q, mhi_q, plo_q, phi_q;
  logic             mrg_q, bad_q, member_q, evalid_q;
  bound_t           elo_q, ehi_q;

  logic             ov_q, om_q, oev_q;
  bound_t           oel_q, oeh_q;
  logic [CNT_W-1:0] ocnt_q;
  logic [1:0]       ost_q;

  // evaluation of one entry
  bound_t a, b;
  logic   push_en, pend_set, mrg_set, stop_now, hit;
  bound_t push_lo, push_hi, mlo_n, mhi_n;
  logic   last, modify, out_free, fin_go, commit, full;

  assign a = rd_q[63:32];
  assign b = rd_q[31:0];

  always_comb begin
    push_en  = 1'b0;
    push_lo  = a;
    push_hi  = b;
    pend_set = 1'b0;
    mrg_set  = mrg_q;
    stop_now = 1'b0;
    hit      = 1'b0;
    mlo_n    = mlo_q;
    mhi_n    = mhi_q;
    if (state_q == S_EV) begin
      case (op_q)
        OP_CONTAINS: hit = (a <= val_q) && (val_q <= b);
        OP_UNION: begin
          if (mrg_q) begin
            push_en = 1'b1;
          end else if (b < lo_q) begin
            push_en = 1'b1;
          end else if (a <= hi_q) begin
            mlo_n = (a < mlo_q) ? a : mlo_q;
            mhi_n = (b > mhi_q) ? b : mhi_q;
          end else begin
            // first range past the merge: emit the merged range, then this one
            push_en  = 1'b1;
            push_lo  = mlo_q;
            push_hi  = mhi_q;
            pend_set = 1'b1;
            mrg_set  = 1'b1;
          end
        end
        OP_SUBTRACT: begin
          if (b < lo_q || a > hi_q) begin
            push_en = 1'b1;
          end else if (a < lo_q) begin
            push_en  = 1'b1;
            push_hi  = lo_q - 32'd1;
            pend_set = (b > hi_q);
          end else if (b > hi_q) begin
            push_en = 1'b1;
            push_lo = hi_q + 32'd1;
          end
        end
        OP_INTERSECT: begin
          if (b >= lo_q && a <= hi_q) begin
            push_en = 1'b1;
            push_lo = (a > lo_q) ? a : lo_q;
            push_hi = (b < hi_q) ? b : hi_q;
          end
        end
        OP_SHIFT_UP: begin
          if (a > ~val_q) begin
            stop_now = 1'b1;
          end else begin
            push_en = 1'b1;
            push_lo = a + val_q;
            push_hi = (b > ~val_q) ? BOUND_MAX : b + val_q;
          end
        end
        OP_SHIFT_DN: begin
          if (b >= val_q) begin
            push_en = 1'b1;
            push_lo = (a < val_q) ? '0 : a - val_q;
            push_hi = b - val_q;
          end
        end
        default: ;
      endcase
    end else if (state_q == S_EV2) begin
      push_en = 1'b1;
      push_lo = plo_q;
      push_hi = phi_q;
    end else if (state_q == S_UFIN) begin
      push_en = 1'b1;
      push_lo = mlo_q;
      push_hi = mhi_q;
    end
  end

  assign last     = (op_q == OP_READ) || (CNT_W'(i_q) + CNT_W'(1) >= count_q);
  assign modify   = (op_q >= OP_UNION) && (op_q <= OP_SHIFT_DN);
  assign out_free = !ov_q || rsp_o.ready;
  assign fin_go   = (state_q == S_FIN) && out_free;
  assign full     = wcnt_q > WCW'(MAX_RANGES);
  assign commit   = fin_go && modify && !bad_q && !full;

  // table RAM: bank bank_q holds the set, the other bank receives the new one
  always_ff @(posedge clk_i) begin
    rd_q <= mem[{bank_q, i_q}];
    if (push_en && wcnt_q < WCW'(MAX_RANGES)) begin
      mem[{~bank_q, wcnt_q[AW-1:0]}] <= {push_lo, push_hi};
    end
  end

  assign req_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bank_q  <= 1'b0;
      count_q <= '0;
      wcnt_q  <= '0;
      i_q     <= '0;
      mrg_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (push_en) begin
        wcnt_q <= wcnt_q + WCW'(1);
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            wcnt_q <= '0;
            i_q    <= '0;
            mrg_q  <= 1'b0;
            if (((req_i.opcode == OP_UNION) || (req_i.opcode == OP_SUBTRACT) ||
                 (req_i.opcode == OP_INTERSECT)) && (req_i.range_low > req_i.range_high)) begin
              state_q <= S_FIN;
            end else if (req_i.opcode == OP_READ) begin
              i_q     <= AW'(req_i.entry_index);
              state_q <= (IXW'(req_i.entry_index) < IXW'(count_q)) ? S_RD : S_FIN;
            end else if (req_i.opcode > OP_READ) begin
              state_q <= S_FIN;
            end else if (count_q == '0) begin
              state_q <= (req_i.opcode == OP_UNION) ? S_UFIN : S_FIN;
            end else begin
              state_q <= S_RD;
            end
          end
        end
        S_RD: state_q <= S_EV;
        S_EV, S_EV2: begin
          mrg_q <= mrg_set;
          if (pend_set) begin
            state_q <= S_EV2;
          end else if (stop_now || last) begin
            state_q <= (op_q == OP_UNION && !mrg_set) ? S_UFIN : S_FIN;
          end else begin
            i_q     <= i_q + AW'(1);
            state_q <= S_RD;
          end
        end
        S_UFIN: state_q <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (commit) begin
        bank_q  <= ~bank_q;
        count_q <= wcnt_q[CNT_W-1:0];
      end
      if (fin_go) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // request fields and working values
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.valid) begin
      op_q     <= req_i.opcode;
      lo_q     <= req_i.range_low;
      hi_q     <= req_i.range_high;
      val_q    <= req_i.operand_value;
      mlo_q    <= req_i.range_low;
      mhi_q    <= req_i.range_high;
      // only the range operations check their bounds
      bad_q    <= (req_i.opcode >= OP_UNION) && (req_i.opcode <= OP_INTERSECT) &&
                  (req_i.range_low > req_i.range_high);
      member_q <= 1'b0;
      evalid_q <= 1'b0;
      elo_q    <= '0;
      ehi_q    <= '0;
    end else if (state_q == S_EV) begin
      mlo_q <= mlo_n;
      mhi_q <= mhi_n;
      if (hit) begin
        member_q <= 1'b1;
      end
      if (op_q == OP_READ) begin
        evalid_q <= 1'b1;
        elo_q    <= a;
        ehi_q    <= b;
      end
      if (pend_set) begin
        plo_q <= (op_q == OP_UNION) ? a : hi_q + 32'd1;
        phi_q <= b;
      end
    end
    if (fin_go) begin
      om_q   <= member_q;
      oev_q  <= evalid_q;
      oel_q  <= elo_q;
      oeh_q  <= ehi_q;
      ocnt_q <= commit ? wcnt_q[CNT_W-1:0] : count_q;
      if (modify && bad_q && op_q <= OP_INTERSECT) begin
        ost_q <= ST_BAD_RANGE;
      end else if (modify && full) begin
        ost_q <= ST_FULL;
      end else begin
        ost_q <= ST_DONE;
      end
    end
  end

  assign rsp_o.valid       = ov_q;
  assign rsp_o.is_member   = om_q;
  assign rsp_o.entry_low   = oel_q;
  assign rsp_o.entry_high  = oeh_q;
  assign rsp_o.entry_valid = oev_q;
  assign rsp_o.range_count = ocnt_q;
  assign rsp_o.status      = ost_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RANGES))
    else $error("range count above capacity");

  a_wcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> wcnt_q <= WCW'(count_q) + WCW'(1))
    else $error("new table grew by more than one range");

  a_bank_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> bank_q != $past(bank_q))
    else $error("commit without bank swap");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (ost_q == ST_DONE || ost_q == ST_FULL || ost_q == ST_BAD_RANGE))
    else $error("undefined status code");

endmodule
